/* hw/rtl/particle_cell_binning_accumulator_macros.svh */
// Assertion macros shared by the binning accumulator RTL.
`ifndef PARTICLE_CELL_BINNING_ACCUMULATOR_MACROS_SVH
`define PARTICLE_CELL_BINNING_ACCUMULATOR_MACROS_SVH

// Property checked on every clk edge outside reset.
`define PCBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen on a clk edge outside reset.
`define PCBA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/pcba_pkg.sv */
// Shared types and constants of the particle cell binning accumulator.
package pcba_pkg;

	localparam int unsigned POS_W     = 32;  // Q16.16 positions, origins, reciprocals
	localparam int unsigned ENTRY_W   = 48;  // Q32.16 store entries
	localparam int unsigned CELL_W    = 4;   // cell index as seen on the result
	localparam int unsigned IDX_W     = 8;   // internal axis index, holds up to 256 cells
	localparam int unsigned COMP_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [POS_W-1:0] INV_RESET = 32'h0010_0000;  // 16.0

	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_ORIGIN_Z = 3'd2,
		CFG_INV_X    = 3'd3,
		CFG_INV_Y    = 3'd4,
		CFG_INV_Z    = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_ACCUM = 1'b0,
		OP_READ  = 1'b1
	} opcode_t;

	// Classified request handed from the binning front to the store back.
	typedef struct packed {
		opcode_t                   op;
		logic                      comp_ok;
		logic                      clamped;
		logic [CELL_W-1:0]         cell_x;
		logic [CELL_W-1:0]         cell_y;
		logic [CELL_W-1:0]         cell_z;
		logic signed [POS_W-1:0]   addend;
	} pcba_item_t;

endpackage

/* hw/rtl/pcba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pcba_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/pcba_queue.sv */
// Short FIFO between the binning front and the store back.
`include "particle_cell_binning_accumulator_macros.svh"

module pcba_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full      = (count_q == (PW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	`PCBA_ASSERT_NEVER(a_push_full, push && full, "queue written while full")
	`PCBA_ASSERT_NEVER(a_pop_empty, pop && !not_empty, "queue read while empty")

endmodule

/* hw/rtl/pcba_front.sv */
// Binning front: configuration registers and the three-stage position-to-cell pipeline.
module pcba_front #(
	parameter int unsigned COMPONENTS = 4,
	parameter int unsigned CELLS_X    = 16,
	parameter int unsigned CELLS_Y    = 16,
	parameter int unsigned CELLS_Z    = 16,
	parameter int unsigned AW         = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pcba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcba_pkg::POS_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic signed [pcba_pkg::POS_W-1:0]    pos_x,
	input  logic signed [pcba_pkg::POS_W-1:0]    pos_y,
	input  logic signed [pcba_pkg::POS_W-1:0]    pos_z,
	input  logic [pcba_pkg::COMP_W-1:0]          component,
	input  logic signed [pcba_pkg::POS_W-1:0]    addend,
	input  logic                                 clear_busy,
	input  logic                                 q_full,
	output logic                                 push,
	output pcba_pkg::pcba_item_t                 push_item,
	output logic [AW-1:0]                        push_addr
);
	import pcba_pkg::*;

	localparam int unsigned CELLS [3] = '{CELLS_X, CELLS_Y, CELLS_Z};

	logic signed [POS_W-1:0] origin_q [3];
	logic [POS_W-1:0]        inv_q [3];

	logic signed [POS_W-1:0] pos_in [3];

	// stage 1: offset from origin
	logic                    valid_s1;
	opcode_t                 op_s1;
	logic [COMP_W-1:0]       comp_s1;
	logic signed [POS_W-1:0] addend_s1;
	logic signed [POS_W:0]   diff_s1 [3];

	// stage 2: scaled offset, integer part only
	logic                    valid_s2;
	opcode_t                 op_s2;
	logic [COMP_W-1:0]       comp_s2;
	logic signed [POS_W-1:0] addend_s2;
	logic [POS_W-1:0]        prod_s2 [3];
	logic                    neg_s2 [3];

	// stage 3: clamped cell and store address
	logic                    valid_s3;
	pcba_item_t              item_s3;
	logic [AW-1:0]           addr_s3;

	logic [2*POS_W-1:0]      prod_full [3];
	logic [IDX_W-1:0]        idx_c [3];
	logic                    clamp_c [3];
	logic [AW-1:0]           addr_c;
	logic                    comp_ok_c;
	logic                    move;
	logic                    take;

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	assign move     = !valid_s3 || !q_full;
	assign in_stall = clear_busy || !move;
	assign take     = in_valid && !in_stall;

	assign push      = valid_s3 && !q_full;
	assign push_item = item_s3;
	assign push_addr = addr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				origin_q[a] <= '0;
				inv_q[a]    <= INV_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ORIGIN_X: origin_q[0] <= cfg_data;
				CFG_ORIGIN_Y: origin_q[1] <= cfg_data;
				CFG_ORIGIN_Z: origin_q[2] <= cfg_data;
				CFG_INV_X:    inv_q[0]    <= cfg_data;
				CFG_INV_Y:    inv_q[1]    <= cfg_data;
				CFG_INV_Z:    inv_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod_full[a] = (2*POS_W)'(diff_s1[a][POS_W-1:0]) * (2*POS_W)'(inv_q[a]);
		end
	end

	// Floor index and clamp. Below the origin clamps to cell 0, flagged only
	// when the reciprocal is nonzero (a zero reciprocal maps everything to 0).
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (neg_s2[a]) begin
				idx_c[a]   = '0;
				clamp_c[a] = |inv_q[a];
			end else if (prod_s2[a] >= POS_W'(CELLS[a])) begin
				idx_c[a]   = IDX_W'(CELLS[a] - 1);
				clamp_c[a] = 1'b1;
			end else begin
				idx_c[a]   = prod_s2[a][IDX_W-1:0];
				clamp_c[a] = 1'b0;
			end
		end
		comp_ok_c = (32'(comp_s2) < COMPONENTS);
		addr_c = AW'(((32'(comp_s2) * CELLS_X + 32'(idx_c[0])) * CELLS_Y
			+ 32'(idx_c[1])) * CELLS_Z + 32'(idx_c[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (move) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			op_s1     <= opcode_t'(opcode);
			comp_s1   <= component;
			addend_s1 <= addend;
			for (int a = 0; a < 3; a++) begin
				diff_s1[a] <= {pos_in[a][POS_W-1], pos_in[a]}
					- {origin_q[a][POS_W-1], origin_q[a]};
			end

			op_s2     <= op_s1;
			comp_s2   <= comp_s1;
			addend_s2 <= addend_s1;
			for (int a = 0; a < 3; a++) begin
				prod_s2[a] <= prod_full[a][2*POS_W-1:POS_W];
				neg_s2[a]  <= diff_s1[a][POS_W];
			end

			item_s3.op      <= op_s2;
			item_s3.comp_ok <= comp_ok_c;
			item_s3.clamped <= clamp_c[0] || clamp_c[1] || clamp_c[2];
			item_s3.cell_x  <= idx_c[0][CELL_W-1:0];
			item_s3.cell_y  <= idx_c[1][CELL_W-1:0];
			item_s3.cell_z  <= idx_c[2][CELL_W-1:0];
			item_s3.addend  <= addend_s2;
			addr_s3         <= addr_c;
		end
	end

endmodule

/* hw/rtl/pcba_back.sv */
// Store back: clearing pass, read-modify-write of the entry store, result register.
`include "particle_cell_binning_accumulator_macros.svh"

module pcba_back #(
	parameter int unsigned DEPTH = 16384,
	parameter int unsigned AW    = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	input  pcba_pkg::pcba_item_t                 q_item,
	input  logic [AW-1:0]                        q_addr,
	output logic                                 q_pop,
	output logic                                 clear_busy,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pcba_pkg::CELL_W-1:0]          cell_x,
	output logic [pcba_pkg::CELL_W-1:0]          cell_y,
	output logic [pcba_pkg::CELL_W-1:0]          cell_z,
	output logic                                 clamped,
	output logic signed [pcba_pkg::ENTRY_W-1:0]  entry_value
);
	import pcba_pkg::*;

	logic                        clearing_q;
	logic [AW-1:0]               clr_cnt_q;

	logic                        valid_s1;
	pcba_item_t                  item_s1;
	logic [AW-1:0]               addr_s1;

	logic                        fwd_valid_q;
	logic [AW-1:0]               fwd_addr_q;
	logic signed [ENTRY_W-1:0]   fwd_data_q;

	logic                        out_valid_q;

	logic                        b_adv;
	logic                        item_wr;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [ENTRY_W-1:0]          ram_wdata;
	logic [ENTRY_W-1:0]          ram_rdata;
	logic signed [ENTRY_W-1:0]   base;
	logic signed [ENTRY_W:0]     sum;
	logic signed [ENTRY_W-1:0]   sat;
	logic signed [ENTRY_W-1:0]   result;

	assign clear_busy = clearing_q;
	assign out_valid  = out_valid_q;

	assign b_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign q_pop   = !clearing_q && q_valid && (!valid_s1 || b_adv);
	assign item_wr = b_adv && item_s1.comp_ok && (item_s1.op == OP_ACCUM);

	assign ram_we    = clearing_q || item_wr;
	assign ram_waddr = clearing_q ? clr_cnt_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : sat;

	pcba_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (q_pop && q_item.comp_ok),
		.raddr (q_addr),
		.rdata (ram_rdata)
	);

	// The read was issued while the previous request wrote; take its value
	// when both hit the same entry.
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == addr_s1)) begin
			base = fwd_data_q;
		end else begin
			base = ram_rdata;
		end
		sum = {base[ENTRY_W-1], base}
			+ {{(ENTRY_W+1-POS_W){item_s1.addend[POS_W-1]}}, item_s1.addend};
		if (sum[ENTRY_W] != sum[ENTRY_W-1]) begin
			sat = sum[ENTRY_W] ? ENTRY_MIN : ENTRY_MAX;
		end else begin
			sat = sum[ENTRY_W-1:0];
		end
		if (!item_s1.comp_ok) begin
			result = '0;
		end else if (item_s1.op == OP_ACCUM) begin
			result = sat;
		end else begin
			result = base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_cnt_q == AW'(DEPTH-1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
			end
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (b_adv) begin
				valid_s1 <= 1'b0;
			end
			if (item_wr) begin
				fwd_valid_q <= 1'b1;
			end
			if (b_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
			addr_s1 <= q_addr;
		end
		if (item_wr) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= sat;
		end
		if (b_adv) begin
			cell_x      <= item_s1.cell_x;
			cell_y      <= item_s1.cell_y;
			cell_z      <= item_s1.cell_z;
			clamped     <= item_s1.clamped;
			entry_value <= result;
		end
	end

	`PCBA_ASSERT_NEVER(a_item_in_clear, clearing_q && valid_s1, "request in store stage during clear")
	`PCBA_ASSERT(a_clear_full, $fell(clearing_q) |-> $past(clr_cnt_q) == AW'(DEPTH - 1), "clear ended early")

endmodule

/* hw/rtl/particle_cell_binning_accumulator.sv */
// Top level of the particle cell binning accumulator.
// Usage:
//   Input channel (in_valid / in_stall): one request per accepted edge carries opcode,
//   pos_x/y/z, component and addend. The position is binned to a cell per axis as
//   floor((pos - origin) * inv_cell), clamped into the grid; opcode accumulate adds
//   addend into the (component, cell) entry with 48-bit saturation, opcode read
//   returns the entry. A component beyond COMPONENTS touches nothing and returns 0.
//   Output channel (out_valid / out_stall): exactly one result per request, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is always
//   high; write only while no request is in flight.
//   Path: binning pipeline, queue, store stage, then the result register on out_valid.
//   Throughput: one request per cycle outside stalls; the binning pipeline, a four-entry
//   queue and the store's single write port each handle one request a cycle, and a
//   read that follows a write to the same entry is forwarded, so repeats do not stall.
//   Reset: config returns to origin 0 and reciprocal 16.0; the store is then swept to
//   zero one entry a cycle, all COMPONENTS*CELLS_X*CELLS_Y*CELLS_Z entries (16384 by
//   default), with in_stall high throughout.
//   Receiver stall: the result register holds; the queue absorbs up to four requests
//   plus the pipeline, after which in_stall rises.
module particle_cell_binning_accumulator #(
	parameter int unsigned COMPONENTS = 4,
	parameter int unsigned CELLS_X    = 16,
	parameter int unsigned CELLS_Y    = 16,
	parameter int unsigned CELLS_Z    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pcba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcba_pkg::POS_W-1:0]           cfg_data,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic signed [pcba_pkg::POS_W-1:0]    pos_x,
	input  logic signed [pcba_pkg::POS_W-1:0]    pos_y,
	input  logic signed [pcba_pkg::POS_W-1:0]    pos_z,
	input  logic [pcba_pkg::COMP_W-1:0]          component,
	input  logic signed [pcba_pkg::POS_W-1:0]    addend,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pcba_pkg::CELL_W-1:0]          cell_x,
	output logic [pcba_pkg::CELL_W-1:0]          cell_y,
	output logic [pcba_pkg::CELL_W-1:0]          cell_z,
	output logic                                 clamped,
	output logic signed [pcba_pkg::ENTRY_W-1:0]  entry_value
);
	import pcba_pkg::*;

	// store holds one entry per component per cell
	localparam int unsigned DEPTH   = COMPONENTS * CELLS_X * CELLS_Y * CELLS_Z;
	localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_W     = $bits(pcba_item_t) + AW;

	logic            clear_busy;
	logic            q_full;
	logic            q_push;
	pcba_item_t      push_item;
	logic [AW-1:0]   push_addr;
	logic            q_pop;
	logic            q_valid;
	logic [Q_W-1:0]  q_data;
	pcba_item_t      q_item;
	logic [AW-1:0]   q_addr;

	assign cfg_ready = 1'b1;
	assign {q_item, q_addr} = q_data;

	// front: config registers, offset, scale, floor and clamp, store address
	pcba_front #(
		.COMPONENTS (COMPONENTS),
		.CELLS_X    (CELLS_X),
		.CELLS_Y    (CELLS_Y),
		.CELLS_Z    (CELLS_Z),
		.AW         (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.component  (component),
		.addend     (addend),
		.clear_busy (clear_busy),
		.q_full     (q_full),
		.push       (q_push),
		.push_item  (push_item),
		.push_addr  (push_addr)
	);

	// decouples binning from the store so either side can stall alone
	pcba_queue #(
		.WIDTH (Q_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_item, push_addr}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.not_empty (q_valid)
	);

	// back: store read, saturating add, write back, result register
	pcba_back #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_addr      (q_addr),
		.q_pop       (q_pop),
		.clear_busy  (clear_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_z      (cell_z),
		.clamped     (clamped),
		.entry_value (entry_value)
	);

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the particle cell binning accumulator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcba_pkg::*;

	// Grid shape of the instance; the checker's own copy of the store uses the same sizes.
	localparam int unsigned N_COMP      = 4;
	localparam int unsigned GRID_X      = 16;
	localparam int unsigned GRID_Y      = 16;
	localparam int unsigned GRID_Z      = 16;
	localparam int unsigned STORE_DEPTH = N_COMP * GRID_X * GRID_Y * GRID_Z;

	localparam int LATENCY         = 5;          // request taken to result shown
	localparam int CYCLE_LIMIT     = 2_000_000;  // slowest correct run stays well under this limit
	localparam int RANDOM_REQUESTS = 1260;
	localparam int RANDOM_PHASES   = 6;
	localparam int FULL_RUN        = 40;         // full-scale adds piled into one entry
	localparam int HOLD_CYCLES     = 120;        // long receiver hold-off
	localparam int HOT_CELLS       = 4;
	localparam int REPORT_LINES    = 50;

	// One particle request as it goes onto the request channel.
	typedef struct packed {
		opcode_t                 op;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic [COMP_W-1:0]       comp;
		logic signed [POS_W-1:0] addend;
	} particle_req_t;

	// What the block must return for one request.
	typedef struct packed {
		logic [CELL_W-1:0]         cx;
		logic [CELL_W-1:0]         cy;
		logic [CELL_W-1:0]         cz;
		logic                      clamped;
		logic signed [ENTRY_W-1:0] entry;
	} bin_result_t;

	// ---------------------------------------------------------------- DUT ports
	logic                       clk;
	logic                       arst_n      = 1'b0;
	logic                       cfg_valid   = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index   = '0;
	logic [POS_W-1:0]           cfg_data    = '0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic                       opcode      = 1'b0;
	logic signed [POS_W-1:0]    pos_x       = '0;
	logic signed [POS_W-1:0]    pos_y       = '0;
	logic signed [POS_W-1:0]    pos_z       = '0;
	logic [COMP_W-1:0]          component   = '0;
	logic signed [POS_W-1:0]    addend      = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic [CELL_W-1:0]          cell_x;
	logic [CELL_W-1:0]          cell_y;
	logic [CELL_W-1:0]          cell_z;
	logic                       clamped;
	logic signed [ENTRY_W-1:0]  entry_value;

	particle_cell_binning_accumulator #(
		.COMPONENTS (N_COMP),
		.CELLS_X    (GRID_X),
		.CELLS_Y    (GRID_Y),
		.CELLS_Z    (GRID_Z)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.component   (component),
		.addend      (addend),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_z      (cell_z),
		.clamped     (clamped),
		.entry_value (entry_value)
	);

	// ------------------------------------------------------- checker state
	// Geometry as the block holds it, tracked from every register write.
	logic signed [POS_W-1:0]   grid_origin [3];
	logic [POS_W-1:0]          grid_inv    [3];
	// Mirror of the accumulator store, indexed (component, x, y, z).
	logic signed [ENTRY_W-1:0] bin_store   [STORE_DEPTH];
	// Results owed by the block, oldest first.
	bin_result_t               expected_bins [$];
	bin_result_t               oldest_bin;
	int                        mismatches  = 0;
	int                        cycle_count = 0;

	// Stimulus shaping: cell width per axis (raw Q16.16) and a few hot cells, so
	// that repeats hit the store's forwarding path.
	int unsigned               geo_w    [3];
	int unsigned               hot_cell [HOT_CELLS][3];
	logic [COMP_W-1:0]         hot_comp [HOT_CELLS];
	bit                        tx_idle   = 1'b0;

	// Receiver controls; written with NBAs so the stall process sees edge-stable values.
	logic                      rx_random = 1'b0;
	logic                      rx_hold   = 1'b0;
	int unsigned               rx_left   = 0;
	int unsigned               rx_roll;

	// ---------------------------------------------------------------- clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: a hang anywhere (lost result, stuck stall) ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("particle_cell_binning_accumulator: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------ reporting
	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LINES)
			$display("%0t: %s", $time, what);
	endtask

	// --------------------------------------------------------- predictor
	// Floor of (pos - origin) * inv in Q32.32, forced into [0, cells-1].
	// A negative offset only counts as clamped when the reciprocal is nonzero:
	// with a zero reciprocal every position maps to cell 0 anyway.
	function automatic logic [CELL_W-1:0] bin_axis(input logic signed [POS_W-1:0] pos,
			input logic signed [POS_W-1:0] org, input logic [POS_W-1:0] inv,
			input int unsigned cells, inout logic hit);
		logic signed [POS_W:0] offset;
		logic [2*POS_W-1:0]    scaled;
		offset = pos - org;
		if (offset < 0) begin
			if (inv != '0)
				hit = 1'b1;
			return '0;
		end
		scaled = offset[POS_W-1:0] * inv;
		if (scaled[2*POS_W-1:POS_W] >= cells) begin
			hit = 1'b1;
			return CELL_W'(cells - 1);
		end
		return CELL_W'(scaled[2*POS_W-1:POS_W]);
	endfunction

	// Bins one request, applies it to the mirror store, returns the owed result.
	function automatic bin_result_t predict_bin(input particle_req_t r);
		bin_result_t             res;
		logic                    hit;
		int unsigned             slot;
		logic signed [ENTRY_W-1:0] stored;
		logic signed [ENTRY_W:0]   total;
		hit         = 1'b0;
		res.cx      = bin_axis(r.px, grid_origin[0], grid_inv[0], GRID_X, hit);
		res.cy      = bin_axis(r.py, grid_origin[1], grid_inv[1], GRID_Y, hit);
		res.cz      = bin_axis(r.pz, grid_origin[2], grid_inv[2], GRID_Z, hit);
		res.clamped = hit;
		stored      = '0;
		// components past the configured count leave the store alone and read 0
		if (r.comp < N_COMP) begin
			slot   = ((r.comp * GRID_X + res.cx) * GRID_Y + res.cy) * GRID_Z + res.cz;
			stored = bin_store[slot];
			if (r.op == OP_ACCUM) begin
				total = stored + r.addend;
				if (total > ENTRY_MAX)
					total = ENTRY_MAX;
				else if (total < ENTRY_MIN)
					total = ENTRY_MIN;
				stored          = total[ENTRY_W-1:0];
				bin_store[slot] = stored;
			end
		end
		res.entry = stored;
		return res;
	endfunction

	// ------------------------------------------------------------- checker
	// Sampled at the edge, so values are the ones the handshake used.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bins.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				oldest_bin = expected_bins.pop_front();
				if (cell_x !== oldest_bin.cx)
					report_mismatch($sformatf("cell_x got %0d want %0d", cell_x, oldest_bin.cx));
				if (cell_y !== oldest_bin.cy)
					report_mismatch($sformatf("cell_y got %0d want %0d", cell_y, oldest_bin.cy));
				if (cell_z !== oldest_bin.cz)
					report_mismatch($sformatf("cell_z got %0d want %0d", cell_z, oldest_bin.cz));
				if (clamped !== oldest_bin.clamped)
					report_mismatch($sformatf("clamped got %b want %b", clamped,
						oldest_bin.clamped));
				if (entry_value !== oldest_bin.entry)
					report_mismatch($sformatf("entry_value got %h want %h", entry_value,
						oldest_bin.entry));
			end
		end
	end

	// ------------------------------------------------------------ receiver
	// Random stall runs, mostly short with a few long; rx_hold forces a long stretch.
	always @(posedge clk) begin
		if (rx_hold) begin
			out_stall <= 1'b1;
		end else if (rx_left != 0) begin
			rx_left <= rx_left - 1;
		end else if (!rx_random) begin
			out_stall <= 1'b0;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 65) begin
				out_stall <= 1'b0;
				rx_left   <= $urandom_range(0, 4);
			end else if (rx_roll < 93) begin
				out_stall <= 1'b1;
				rx_left   <= $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b1;
				rx_left   <= $urandom_range(10, 40);
			end
		end
	end

	// -------------------------------------------------------------- sender
	// Presents one request and holds it until taken. Valid is left high so a
	// following request goes out back to back; idle_for lowers it.
	task automatic send_request(input particle_req_t r);
		in_valid  <= 1'b1;
		opcode    <= r.op;
		pos_x     <= r.px;
		pos_y     <= r.py;
		pos_z     <= r.pz;
		component <= r.comp;
		addend    <= r.addend;
		do @(posedge clk); while (in_stall);
		expected_bins = {expected_bins, predict_bin(r)};
	endtask

	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic int tx_gap();
		int unsigned roll;
		if (!tx_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Sender pause until every owed result is in, then the pipeline depth again
	// so nothing is still moving when the config changes.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_bins.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// ------------------------------------------------------- configuration
	task automatic write_reg(input cfg_reg_t idx, input logic [POS_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ORIGIN_X: grid_origin[0] = val;
			CFG_ORIGIN_Y: grid_origin[1] = val;
			CFG_ORIGIN_Z: grid_origin[2] = val;
			CFG_INV_X:    grid_inv[0]    = val;
			CFG_INV_Y:    grid_inv[1]    = val;
			CFG_INV_Z:    grid_inv[2]    = val;
			default: ;
		endcase
	endtask

	// All six registers, only once the block has gone quiet.
	task automatic set_geometry(input logic [POS_W-1:0] ox, oy, oz,
			input logic [POS_W-1:0] ix, iy, iz);
		wait_idle();
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_INV_X, ix);
		write_reg(CFG_INV_Y, iy);
		write_reg(CFG_INV_Z, iz);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------ request makers
	function automatic particle_req_t make_request(input opcode_t op,
			input logic [POS_W-1:0] x, y, z, input logic [COMP_W-1:0] comp,
			input logic [POS_W-1:0] add);
		particle_req_t r;
		r.op     = op;
		r.px     = x;
		r.py     = y;
		r.pz     = z;
		r.comp   = comp;
		r.addend = add;
		return r;
	endfunction

	function automatic int unsigned axis_cells(input int axis);
		case (axis)
			0:       return GRID_X;
			1:       return GRID_Y;
			default: return GRID_Z;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] inv_for(input int unsigned w);
		return POS_W'((64'd1 << 32) / w);
	endfunction

	// Somewhere inside the given cell of the current geometry.
	function automatic logic [POS_W-1:0] cell_pos(input int axis, input int unsigned cell_idx);
		return grid_origin[axis] + cell_idx * geo_w[axis] + $urandom_range(0, geo_w[axis] - 1);
	endfunction

	// Mostly inside the domain, some on its borders, the rest anywhere.
	function automatic logic [POS_W-1:0] axis_pos(input int axis);
		int unsigned roll;
		logic [POS_W-1:0] span;
		roll = $urandom_range(0, 99);
		span = axis_cells(axis) * geo_w[axis];
		if (roll < 75)
			return cell_pos(axis, $urandom_range(0, axis_cells(axis) - 1));
		if (roll < 90) begin
			case ($urandom_range(0, 3))
				0:       return grid_origin[axis] + span;      // exactly at the maximum
				1:       return grid_origin[axis] - 1;         // just below
				2:       return grid_origin[axis];
				default: return grid_origin[axis] + span - 1;  // last code inside
			endcase
		end
		return $urandom;
	endfunction

	function automatic particle_req_t make_particle();
		particle_req_t r;
		int unsigned   h;
		r.op   = ($urandom_range(0, 99) < 70) ? OP_ACCUM : OP_READ;
		r.comp = COMP_W'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 40) begin
			h    = $urandom_range(0, HOT_CELLS - 1);
			r.px = cell_pos(0, hot_cell[h][0]);
			r.py = cell_pos(1, hot_cell[h][1]);
			r.pz = cell_pos(2, hot_cell[h][2]);
			if ($urandom_range(0, 1))
				r.comp = hot_comp[h];
		end else begin
			r.px = axis_pos(0);
			r.py = axis_pos(1);
			r.pz = axis_pos(2);
		end
		case ($urandom_range(0, 9))
			0:       r.addend = 32'h7FFF_FFFF;
			1:       r.addend = 32'h8000_0000;
			2, 3, 4: r.addend = $urandom;
			default: r.addend = $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
		endcase
		return r;
	endfunction

	task automatic pick_hot_cells();
		int h;
		int axis;
		for (h = 0; h < HOT_CELLS; h++) begin
			for (axis = 0; axis < 3; axis++)
				hot_cell[h][axis] = $urandom_range(0, axis_cells(axis) - 1);
			hot_comp[h] = COMP_W'($urandom_range(0, 3));
		end
	endtask

	// --------------------------------------------------------------- tests
	// Reset geometry: origin 0, reciprocal 16.0, so one cell is 1/16 unit (0x1000).
	// Requests queue up behind the clearing sweep that follows reset.
	task automatic test_default_binning();
		send_request(make_request(OP_ACCUM, 32'h0, 32'h0, 32'h0, 2'd0, 32'h7FFF_FFFF));
		send_request(make_request(OP_ACCUM, 32'h0, 32'h0, 32'h0, 2'd0, 32'h8000_0000));
		send_request(make_request(OP_READ, 32'h0FFF, 32'h0, 32'h0, 2'd0, 32'hFFFF_FFFF));
		send_request(make_request(OP_ACCUM, 32'h0_FFFF, 32'h0_F000, 32'h0_8000, 2'd3,
			32'h0001_2345));
		// position exactly on the domain maximum lands in the last cell, flagged
		send_request(make_request(OP_ACCUM, 32'h1_0000, 32'h1_0000, 32'h1_0000, 2'd1,
			32'h0000_0100));
		// below the domain along x only
		send_request(make_request(OP_ACCUM, 32'hFFFF_FFFF, 32'h1000, 32'h2000, 2'd2,
			32'hFFFF_0000));
		send_request(make_request(OP_READ, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 2'd1,
			32'h0));
		send_request(make_request(OP_READ, 32'h0_F800, 32'h0_F001, 32'h0_8FFF, 2'd3, 32'h0));
	endtask

	// Register values at their limits, including a zero reciprocal with a
	// negative offset (not flagged) and full-scale reciprocals.
	task automatic test_register_extremes();
		set_geometry(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1);
		send_request(make_request(OP_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 2'd0,
			32'h0000_0005));
		send_request(make_request(OP_ACCUM, 32'h8000_0010, 32'h0, 32'h7FFF_FFFF, 2'd1,
			32'h0000_1000));
		send_request(make_request(OP_ACCUM, 32'h8000_0011, 32'h8000_0000, 32'hFFFF_FFFF,
			2'd2, 32'h1234_5678));
		send_request(make_request(OP_READ, 32'h8000_0010, 32'h1234_5678, 32'h0000_0001,
			2'd1, 32'h0));
		set_geometry(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
			INV_RESET);
		send_request(make_request(OP_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			2'd3, 32'h8000_0000));
		send_request(make_request(OP_ACCUM, 32'h7FFF_FFFF, 32'h8000_0003, 32'h8000_0000,
			2'd3, 32'h8000_0000));
		send_request(make_request(OP_READ, 32'h0, 32'h8000_0003, 32'h8000_0FFF, 2'd3,
			32'h0));
	endtask

	// Receiver holds off for a long stretch while requests keep coming, so the
	// queue fills and in_stall rises; then the sender waits for everything back.
	task automatic test_backpressure();
		int i;
		geo_w = '{32'h1000, 32'h1000, 32'h1000};
		set_geometry(32'h0, 32'h0, 32'h0, INV_RESET, INV_RESET, INV_RESET);
		pick_hot_cells();
		tx_idle    = 1'b0;
		rx_random <= 1'b0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		for (i = 0; i < 48; i++)
			send_request(make_particle());
		wait_idle();
	endtask

	// Full-scale addends piled into one entry each way, then stepped back.
	task automatic test_full_scale_addends();
		particle_req_t r;
		tx_idle    = 1'b0;
		rx_random <= 1'b0;
		r = make_request(OP_ACCUM, 32'h5000, 32'h6000, 32'h7000, 2'd2, 32'h7FFF_FFFF);
		repeat (FULL_RUN) send_request(r);
		r.addend = 32'h8000_0000;
		repeat (3) send_request(r);
		r.op = OP_READ;
		send_request(r);
		r = make_request(OP_ACCUM, 32'hA000, 32'h3000, 32'hE000, 2'd1, 32'h8000_0000);
		repeat (FULL_RUN) send_request(r);
		r.addend = 32'h7FFF_FFFF;
		repeat (2) send_request(r);
		r.op = OP_READ;
		send_request(r);
	endtask

	// Phases of random geometry; idling differs per phase so some run flat out.
	task automatic test_random_binning();
		int phase;
		int axis;
		int i;
		logic [POS_W-1:0] org [3];
		logic [POS_W-1:0] inv [3];
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			for (axis = 0; axis < 3; axis++) begin
				case ($urandom_range(0, 6))
					0:       geo_w[axis] = 32'h800;
					1:       geo_w[axis] = 32'h1000;
					2:       geo_w[axis] = 32'h3000;
					3:       geo_w[axis] = 32'h2A00;
					4:       geo_w[axis] = 32'h1_0000;
					5:       geo_w[axis] = 32'h10_0000;
					default: geo_w[axis] = 7;
				endcase
				org[axis] = $urandom_range(0, 32'hE000_0000) - 32'h7000_0000;
				inv[axis] = inv_for(geo_w[axis]);
			end
			set_geometry(org[0], org[1], org[2], inv[0], inv[1], inv[2]);
			pick_hot_cells();
			tx_idle    = (phase != 1 && phase != 3);
			rx_random <= (phase != 1 && phase != 4);
			for (i = 0; i < RANDOM_REQUESTS / RANDOM_PHASES; i++) begin
				send_request(make_particle());
				idle_for(tx_gap());
			end
		end
	endtask

	// ---------------------------------------------------------------- main
	initial begin
		int k;
		grid_origin = '{32'h0, 32'h0, 32'h0};
		grid_inv    = '{INV_RESET, INV_RESET, INV_RESET};
		for (k = 0; k < STORE_DEPTH; k++)
			bin_store[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_default_binning();
		test_register_extremes();
		test_backpressure();
		test_full_scale_addends();
		test_random_binning();

		rx_random <= 1'b0;
		wait_idle();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("particle_cell_binning_accumulator: match");
		else
			$display("particle_cell_binning_accumulator: mismatch");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pcba_pkg.sv
hw/rtl/pcba_ram.sv
hw/rtl/pcba_queue.sv
hw/rtl/pcba_front.sv
hw/rtl/pcba_back.sv
hw/rtl/particle_cell_binning_accumulator.sv
tb/sv/tb.sv
